@@ hdl/serial_rgb_command_led_driver_assert.svh @@
// Assertion macros for the serial RGB command LED driver checker.
// No dependencies; included by the checker file only.
`ifndef SERIAL_RGB_COMMAND_LED_DRIVER_ASSERT_SVH
`define SERIAL_RGB_COMMAND_LED_DRIVER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define SRGB_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("srgb: same-cycle check failed");

// Next-cycle implication, disabled while reset is low
`define SRGB_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("srgb: next-cycle check failed");

`endif

@@ hdl/srgb_pkg.sv @@
// Shared types, constants and helpers for the serial RGB command LED driver.
// No dependencies; imported by the front end, the back end and the top level.
package srgb_pkg;

	// Send sequencer stages
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ZERO,
		ST_MID,
		ST_COLOR,
		ST_END
	} stage_t;

	// Classified input item, front to back
	typedef struct packed {
		logic       is_tick;
		logic       is_null;
		logic       is_start;
		logic [3:0] hdr_hit;
		logic [3:0] nibble;
	} item_t;

	// One result item
	typedef struct packed {
		logic din_high;
		logic din_low;
		logic busy;
		logic ok;
		logic dropped;
	} result_t;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Configuration write
	typedef struct packed {
		logic                  valid;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_TICKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAUSE_TICKS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT   = 2'd2;

	// Register reset values
	localparam logic [15:0] PHASE_RESET = 16'd1;
	localparam logic [15:0] PAUSE_RESET = 16'd500;
	localparam logic [7:0]  LED_RESET   = 8'd3;

	// Command framing: "rgb=" then six hex digits
	localparam logic [3:0] CMD_LEN  = 4'd10;
	localparam logic [3:0] HDR_LEN  = 4'd4;
	localparam logic [7:0] CHAR_NUL = 8'h00;
	localparam logic [7:0] HEADER [4] = '{8'h72, 8'h67, 8'h62, 8'h3D};

	// Hex digit value, anything else reads as zero
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [7:0] t;
		t = 8'h00;
		if (c >= 8'h30 && c <= 8'h39) begin
			t = c - 8'h30;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			t = c + 8'h0A - 8'h41;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			t = c + 8'h0A - 8'h61;
		end
		return t[3:0];
	endfunction

endpackage

@@ hdl/srgb_fifo.sv @@
// Small register queue used between the stages of the LED driver.
// No package dependencies.
module srgb_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	output logic             full,
	input  logic [WIDTH-1:0] din,
	input  logic             rd,
	output logic             empty,
	output logic [WIDTH-1:0] dout
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr, do_rd;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign dout  = slot_q[rd_ptr_q];

	// Store the incoming entry
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/srgb_front.sv @@
// Front end of the LED driver: accepts items and classifies received bytes.
// Depends on srgb_pkg.
module srgb_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic            op,
	input  logic [7:0]      rx_byte,
	output logic            q_wr,
	input  logic            q_full,
	output srgb_pkg::item_t q_item
);
	import srgb_pkg::*;

	item_t cls;
	item_t item_s1;
	logic  v_s1;
	logic  accept;

	// Decode the byte against the header and as a hex digit
	always_comb begin
		cls.is_tick  = op;
		cls.is_null  = (rx_byte == CHAR_NUL);
		cls.is_start = (rx_byte == HEADER[0]);
		for (int i = 0; i < 4; i++) begin
			cls.hdr_hit[i] = (rx_byte == HEADER[i]);
		end
		cls.nibble = hex_value(rx_byte);
	end

	assign full   = v_s1 && q_full;
	assign accept = push && !full;
	assign q_wr   = v_s1;
	assign q_item = item_s1;

	// Hold the classified item until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (!q_full) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= cls;
		end
	end

endmodule

@@ hdl/srgb_back.sv @@
// Back end of the LED driver: command collector, send sequencer and registers.
// Depends on srgb_pkg.
module srgb_back #(
	parameter int COLOR_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  srgb_pkg::cfg_wr_t cfg,
	input  logic              in_empty,
	input  srgb_pkg::item_t   in_item,
	output logic              in_rd,
	input  logic              out_full,
	output logic              out_wr,
	output srgb_pkg::result_t out_res
);
	import srgb_pkg::*;

	localparam int K_W = (COLOR_BITS > 1) ? $clog2(COLOR_BITS) : 1;
	localparam logic [K_W-1:0] K_LAST = K_W'(COLOR_BITS - 1);

	// Configuration registers
	logic [15:0] phase_q, pause_q;
	logic [7:0]  ledcnt_q;

	// Collector state
	logic [3:0]  cc_q, cc_d;
	logic        hm_q, hm_d;
	logic [23:0] color_q, color_d;

	// Sequencer state
	stage_t         stage_q, stage_d;
	logic [7:0]     led_q, led_d;
	logic [1:0]     col_q, col_d;
	logic [K_W-1:0] k_q, k_d;
	logic           half_q, half_d;
	logic [16:0]    tick_q, tick_d;

	logic        take;
	logic        enter;
	stage_t      enter_tgt;
	logic        hm_n;
	logic [15:0] plen;
	logic [16:0] tick_inc, mid_lim;
	logic [8:0]  led_inc;
	logic [1:0]  lv;
	result_t     res;

	// Pin levels for a given sequencer position
	function automatic logic [1:0] pin_levels(input stage_t s, input logic h,
			input logic [1:0] c, input logic [K_W-1:0] k, input logic [23:0] w);
		logic [3:0] idx;
		logic [7:0] val;
		logic       b;
		idx = 4'(COLOR_BITS - 1) - 4'(k);
		unique case (c)
			2'd0:    val = w[7:0];
			2'd1:    val = w[15:8];
			default: val = w[23:16];
		endcase
		b = (s == ST_COLOR) && !idx[3] && val[idx[2:0]];
		if ((s == ST_ZERO || s == ST_COLOR) && !h) begin
			return {b, b};
		end
		return 2'b01;
	endfunction

	// Stage actually entered, skipping empty passes
	function automatic stage_t entered(input stage_t s, input logic [7:0] n);
		stage_t r;
		r = s;
		if (n == 8'd0 && s == ST_ZERO) begin
			r = ST_MID;
		end else if (n == 8'd0 && s == ST_COLOR) begin
			r = ST_END;
		end
		return r;
	endfunction

	assign take     = !in_empty && !out_full;
	assign in_rd    = take;
	assign out_wr   = take;
	assign out_res  = res;
	assign plen     = (phase_q == 16'd0) ? 16'd1 : phase_q;
	assign tick_inc = tick_q + 17'd1;
	assign mid_lim  = {1'b0, plen} + {1'b0, pause_q};
	assign led_inc  = {1'b0, led_q} + 9'd1;

	// Execute one item
	always_comb begin
		cc_d      = cc_q;
		hm_d      = hm_q;
		color_d   = color_q;
		stage_d   = stage_q;
		led_d     = led_q;
		col_d     = col_q;
		k_d       = k_q;
		half_d    = half_q;
		tick_d    = tick_q;
		enter     = 1'b0;
		enter_tgt = ST_IDLE;
		hm_n      = hm_q;
		res       = '0;
		lv        = 2'b01;

		if (take && in_item.is_tick) begin
			// report the levels of this tick, then consume it
			lv       = pin_levels(stage_q, half_q, col_q, k_q, color_q);
			res.busy = (stage_q != ST_IDLE);
			unique case (stage_q)
				ST_IDLE: begin
				end
				ST_ZERO, ST_COLOR: begin
					if (tick_inc >= {1'b0, plen}) begin
						tick_d = '0;
						if (!half_q) begin
							half_d = 1'b1;
						end else begin
							half_d = 1'b0;
							if (k_q == K_LAST) begin
								k_d = '0;
								if (col_q == 2'd2) begin
									col_d = '0;
									if (led_inc >= {1'b0, ledcnt_q}) begin
										enter     = 1'b1;
										enter_tgt = (stage_q == ST_ZERO) ? ST_MID : ST_END;
									end else begin
										led_d = led_inc[7:0];
									end
								end else begin
									col_d = col_q + 2'd1;
								end
							end else begin
								k_d = k_q + 1'b1;
							end
						end
					end else begin
						tick_d = tick_inc;
					end
				end
				ST_MID: begin
					if (tick_inc >= mid_lim) begin
						enter     = 1'b1;
						enter_tgt = ST_COLOR;
					end else begin
						tick_d = tick_inc;
					end
				end
				ST_END: begin
					if (tick_inc >= {1'b0, plen}) begin
						enter     = 1'b1;
						enter_tgt = ST_IDLE;
					end else begin
						tick_d = tick_inc;
					end
				end
				default: begin
					enter     = 1'b1;
					enter_tgt = ST_IDLE;
				end
			endcase
		end else if (take) begin
			// collect the byte, or drop it while sending
			priority if (stage_q != ST_IDLE) begin
				res.dropped = 1'b1;
			end else if (in_item.is_null) begin
				cc_d = '0;
				hm_d = 1'b0;
			end else if (cc_q == 4'd0 && !in_item.is_start) begin
				cc_d = cc_q;
			end else begin
				if (cc_q < HDR_LEN) begin
					if (!in_item.hdr_hit[cc_q[1:0]]) begin
						hm_n = 1'b1;
					end
				end else begin
					color_d = {color_q[19:0], in_item.nibble};
				end
				if (cc_q + 4'd1 >= CMD_LEN) begin
					if (!hm_n) begin
						res.ok    = 1'b1;
						enter     = 1'b1;
						enter_tgt = ST_ZERO;
					end
					cc_d = '0;
					hm_d = 1'b0;
				end else begin
					cc_d = cc_q + 4'd1;
					hm_d = hm_n;
				end
			end
		end

		// Start a new stage with cleared counters
		if (enter) begin
			stage_d = entered(enter_tgt, ledcnt_q);
			led_d   = '0;
			col_d   = '0;
			k_d     = '0;
			half_d  = 1'b0;
			tick_d  = '0;
		end

		// A byte reports the levels after it is handled
		if (take && !in_item.is_tick) begin
			lv       = pin_levels(stage_d, half_d, col_d, k_d, color_d);
			res.busy = (stage_d != ST_IDLE);
		end
		res.din_high = lv[1];
		res.din_low  = lv[0];
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q    <= '0;
			hm_q    <= 1'b0;
			color_q <= '0;
			stage_q <= ST_IDLE;
			led_q   <= '0;
			col_q   <= '0;
			k_q     <= '0;
			half_q  <= 1'b0;
			tick_q  <= '0;
		end else begin
			cc_q    <= cc_d;
			hm_q    <= hm_d;
			color_q <= color_d;
			stage_q <= stage_d;
			led_q   <= led_d;
			col_q   <= col_d;
			k_q     <= k_d;
			half_q  <= half_d;
			tick_q  <= tick_d;
		end
	end

	// Configuration writes; an unused index is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PHASE_RESET;
			pause_q  <= PAUSE_RESET;
			ledcnt_q <= LED_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_PHASE_TICKS: phase_q  <= cfg.data;
				REG_PAUSE_TICKS: pause_q  <= cfg.data;
				REG_LED_COUNT:   ledcnt_q <= cfg.data[7:0];
				default: begin
				end
			endcase
		end
	end

endmodule

@@ hdl/serial_rgb_command_led_driver.sv @@
// Top level of the serial RGB command LED driver.
// Depends on srgb_pkg, srgb_fifo, srgb_front and srgb_back.
//
// Bytes and time ticks enter through a queue-style push port; results leave
// through a pop port, one result per item, in order. While neither queue is
// full, the block sustains one item per clock cycle: the back end executes
// each item as it reads it from the item queue. When nothing stalls, an item
// passes the front register, then the item queue, and its result then shows
// on the result ports from the result queue, which holds it until popped.
// A command "rgb=RRGGBB" sends an all-zero pass, a latch with pause, the
// colour pass and a final latch; all timing counts tick items, not clocks.
// Configuration writes are always ready and take effect at once.
module serial_rgb_command_led_driver #(
	parameter int COLOR_BITS  = 8,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic                           op,
	input  logic [7:0]                     rx_byte,
	output logic                           empty,
	input  logic                           pop,
	output logic                           din_high,
	output logic                           din_low,
	output logic                           busy_res,
	output logic                           command_ok,
	output logic                           byte_dropped,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [srgb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srgb_pkg::CFG_DATA_W-1:0] cfg_data
);
	import srgb_pkg::*;

	item_t   f_item, b_item;
	logic    f_wr, f_full;
	logic    b_empty, b_rd;
	logic    r_wr, r_full;
	result_t r_in, r_out;
	cfg_wr_t cfg;

	assign cfg_ready = 1'b1;
	assign cfg.valid = cfg_valid;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	srgb_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.op      (op),
		.rx_byte (rx_byte),
		.q_wr    (f_wr),
		.q_full  (f_full),
		.q_item  (f_item)
	);

	// Decouple classification from execution
	srgb_fifo #(
		.WIDTH ($bits(item_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_item_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (f_wr),
		.full   (f_full),
		.din    (f_item),
		.rd     (b_rd),
		.empty  (b_empty),
		.dout   (b_item)
	);

	srgb_back #(
		.COLOR_BITS (COLOR_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_empty (b_empty),
		.in_item  (b_item),
		.in_rd    (b_rd),
		.out_full (r_full),
		.out_wr   (r_wr),
		.out_res  (r_in)
	);

	// Hold results until the consumer pops them
	srgb_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (r_wr),
		.full   (r_full),
		.din    (r_in),
		.rd     (pop),
		.empty  (empty),
		.dout   (r_out)
	);

	assign din_high     = r_out.din_high;
	assign din_low      = r_out.din_low;
	assign busy_res     = r_out.busy;
	assign command_ok   = r_out.ok;
	assign byte_dropped = r_out.dropped;

endmodule

@@ hdl/srgb_checker.sv @@
// Port-level checks for the serial RGB command LED driver, bound to the top.
// Depends on serial_rgb_command_led_driver_assert.svh.
`include "serial_rgb_command_led_driver_assert.svh"

module srgb_checker (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input logic pop,
	input logic din_high,
	input logic din_low,
	input logic busy_res,
	input logic command_ok,
	input logic byte_dropped
);
	// A byte is either collected or dropped, never both
	`SRGB_ASSERT_IMPLY(a_ok_xor_drop, clk, arst_n, !empty && command_ok, !byte_dropped)
	// A completed command always starts a sequence, on a low first phase
	`SRGB_ASSERT_IMPLY(a_ok_starts, clk, arst_n, !empty && command_ok, busy_res && !din_high)
	// Idle pins rest at the latch level
	`SRGB_ASSERT_IMPLY(a_idle_pins, clk, arst_n, !empty && !busy_res, !din_high && din_low)
	// The first pin is never high while the second is low
	`SRGB_ASSERT_IMPLY(a_pin_pair, clk, arst_n, !empty && din_high, din_low)
	// A waiting result stays until popped
	`SRGB_ASSERT_NEXT(a_res_held, clk, arst_n, !empty && !pop, !empty)
endmodule

bind serial_rgb_command_led_driver srgb_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.empty        (empty),
	.pop          (pop),
	.din_high     (din_high),
	.din_low      (din_low),
	.busy_res     (busy_res),
	.command_ok   (command_ok),
	.byte_dropped (byte_dropped)
);
